// ===== design/osrb_pkg.sv =====
package osrb_pkg;

    localparam int SLOT_W    = 32;
    localparam int VALUE_W   = 64;
    localparam int NODE_W    = 32;
    localparam int DIGIT_W   = 8;
    localparam int MOD_STEPS = SLOT_W / DIGIT_W;
    localparam int STEP_W    = $clog2(MOD_STEPS);

    // APB byte address of own_node_id
    localparam logic [1:0] ADDR_OWN_NODE = 2'd0;

    typedef enum logic [1:0] {
        KIND_RELEASED  = 2'd0,
        KIND_DUPLICATE = 2'd1,
        KIND_DROPPED   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_CHECK,
        S_WALK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value_tag;
        logic               is_set_master;
    } t_in;

    typedef struct packed {
        t_kind              kind;
        logic [SLOT_W-1:0]  released_slot;
        logic [VALUE_W-1:0] released_tag;
        logic [NODE_W-1:0]  origin_node;
        logic [NODE_W-1:0]  master_now;
        logic               became_master;
        logic               last;
    } t_out;

endpackage

// ===== design/in_order_slot_release_buffer.sv =====
// In-order slot release buffer.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one beat carries a
// decided value tagged with its slot. Slots may arrive in any order.
// Output channel (o_out_valid / i_out_ready / o_out_data): one beat per
// result. An input beat yields one duplicate or out-of-window report, or
// nothing, or a run of released slots in slot order; the final beat of the
// run carries last. The APB port holds own_node_id at address 0.
//
// Timing: a beat is taken in the idle cycle, its ring index is reduced from
// the slot one byte per cycle, then the check state decides and writes the
// ring, or loads a report once the output register is free. Per freed slot
// the walk state reads the ring entry and the emit state loads the output
// register, since the ring memory's read data is registered. A new beat is
// taken only once the block is back in the idle state.
//
// Reset clears the filled marks, the slot counters, the master register and
// own_node_id; ring contents stay undefined and are never read unfilled.
// A stalled receiver holds the output register; the walk waits on it.
module in_order_slot_release_buffer #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  osrb_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output osrb_pkg::t_out                    o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [1:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    import osrb_pkg::*;

    localparam int IDXW  = $clog2(WINDOW_DEPTH);
    localparam int RAM_W = VALUE_W + 1;

    // Control state
    t_state              r_state, n_state;
    logic [WINDOW_DEPTH-1:0] r_filled;
    logic [SLOT_W-1:0]   r_released_upto;
    logic [SLOT_W-1:0]   r_highest_decided;
    logic [IDXW-1:0]     r_rel_idx;
    logic [NODE_W-1:0]   r_master;
    logic [NODE_W-1:0]   r_own;
    logic                r_out_valid;

    // Payload holding registers
    t_in                 r_in;
    logic [IDXW-1:0]     r_idx;
    t_out                r_out, n_out;

    // Handshake and sequencing strobes
    logic                mod_start;
    logic                mod_done;
    logic [IDXW-1:0]     mod_rem;
    logic                out_free;
    logic                load_out;
    logic                do_insert;
    logic                do_release;
    logic                do_master;
    logic [IDXW-1:0]     next_idx;
    logic                walk_more;
    logic                is_dup;
    logic                is_far;
    logic [RAM_W-1:0]    ram_rd_data;
    logic [VALUE_W-1:0]  ent_value;
    logic                ent_cmd;
    logic [NODE_W-1:0]   ent_origin;

    // Configuration port: one register, no wait states.
    assign pready = 1'b1;
    assign prdata = r_own;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own <= '0;
        end else if (psel && penable && pwrite) begin
            // Drop writes to addresses that hold no register.
            if (paddr == ADDR_OWN_NODE) begin
                r_own <= pwdata;
            end
        end
    end

    // Ring index of the incoming slot (slot modulo window depth).
    osrb_mod #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_slot  (i_in_data.slot),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // Ring of stored values: {command flag, value id}.
    osrb_ram #(
        .WIDTH(RAM_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (do_insert),
        .i_wr_addr (r_idx),
        .i_wr_data ({r_in.is_set_master, r_in.value_tag}),
        .i_rd_en   (do_release),
        .i_rd_addr (next_idx),
        .o_rd_data (ram_rd_data)
    );

    assign ent_cmd    = ram_rd_data[RAM_W-1];
    assign ent_value  = ram_rd_data[VALUE_W-1:0];
    assign ent_origin = ent_value[NODE_W-1:0];

    // Ring slot that follows the last released one; wraps at the depth.
    assign next_idx = (r_rel_idx == IDXW'(WINDOW_DEPTH - 1)) ? '0 : r_rel_idx + IDXW'(1);

    // The next slot is releasable when it is decided and its mark is set.
    assign walk_more = (r_released_upto < r_highest_decided) && r_filled[next_idx];

    // Already released, or already held in the ring.
    assign is_dup = (r_in.slot <= r_released_upto) || r_filled[r_idx];
    // Beyond the window; widen so the bound cannot wrap.
    assign is_far = {1'b0, r_in.slot} >
                    ({1'b0, r_released_upto} + (SLOT_W+1)'(WINDOW_DEPTH));

    // The output register frees up when empty or drained this cycle.
    assign out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (is_dup || is_far) begin
                    if (out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                n_state = walk_more ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = walk_more ? S_WALK : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_in_ready = 1'b0;
        mod_start  = 1'b0;
        load_out   = 1'b0;
        do_insert  = 1'b0;
        do_release = 1'b0;
        do_master  = 1'b0;
        n_out      = r_out;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                mod_start  = i_in_valid;
            end
            S_CHECK: begin
                if (is_dup || is_far) begin
                    // Report the offending slot and drop the beat.
                    load_out                = out_free;
                    n_out.kind              = is_dup ? KIND_DUPLICATE : KIND_DROPPED;
                    n_out.released_slot     = r_in.slot;
                    n_out.released_tag      = '0;
                    n_out.origin_node       = '0;
                    n_out.master_now        = r_master;
                    n_out.became_master     = 1'b0;
                    n_out.last              = 1'b1;
                end else begin
                    do_insert = 1'b1;
                end
            end
            S_WALK: begin
                // Fetch the entry, clear its mark, advance the release point.
                do_release = walk_more;
            end
            S_EMIT: begin
                if (out_free) begin
                    load_out                = 1'b1;
                    do_master               = ent_cmd;
                    n_out.kind              = KIND_RELEASED;
                    n_out.released_slot     = r_released_upto;
                    n_out.released_tag      = ent_value;
                    n_out.origin_node       = ent_origin;
                    n_out.master_now        = ent_cmd ? ent_origin : r_master;
                    n_out.became_master     = ent_cmd && (ent_origin == r_own);
                    n_out.last              = !walk_more;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_filled          <= '0;
            r_released_upto   <= '0;
            r_highest_decided <= '0;
            r_rel_idx         <= '0;
            r_master          <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_insert) begin
                r_filled[r_idx] <= 1'b1;
                if (r_in.slot > r_highest_decided) begin
                    r_highest_decided <= r_in.slot;
                end
            end
            if (do_release) begin
                r_filled[next_idx] <= 1'b0;
                r_released_upto    <= r_released_upto + SLOT_W'(1);
                r_rel_idx          <= next_idx;
            end
            if (do_master) begin
                r_master <= ent_origin;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (mod_start) begin
            r_in <= i_in_data;
        end
        if (mod_done) begin
            r_idx <= mod_rem;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Release point never passes the highest decided slot.
    a_rel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_released_upto <= r_highest_decided)
        else $error("released slot passed highest decided slot");

    // An entry being emitted has already had its mark cleared.
    a_emit_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> !r_filled[r_rel_idx])
        else $error("emitted slot still marked filled");

    // An insert leaves its ring entry marked.
    a_insert_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_insert |=> r_filled[$past(r_idx)])
        else $error("inserted slot not marked filled");

    // The decision cycle always follows a finished index reduction.
    a_check_after_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && mod_done) |=> r_state == S_CHECK)
        else $error("index reduction finished without a decision cycle");

endmodule

// ===== design/osrb_ram.sv =====
module osrb_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/osrb_mod.sv =====
module osrb_mod #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [osrb_pkg::SLOT_W-1:0]     i_slot,
    output logic                            o_done,
    output logic [$clog2(WINDOW_DEPTH)-1:0] o_rem
);

    import osrb_pkg::*;

    localparam int IDXW = $clog2(WINDOW_DEPTH);
    localparam logic [IDXW:0] DIVISOR = (IDXW+1)'(WINDOW_DEPTH);

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_shift, n_shift;
    logic [IDXW-1:0]   r_rem, n_rem;

    // Fold one digit of the slot into the running remainder, top bits first.
    always_comb begin
        logic [IDXW-1:0] rem;
        logic [IDXW:0]   t;
        rem = r_rem;
        t   = '0;
        for (int k = 0; k < DIGIT_W; k++) begin
            t = {rem, r_shift[SLOT_W-1-k]};
            if (t >= DIVISOR) begin
                t = t - DIVISOR;
            end
            rem = t[IDXW-1:0];
        end
        n_rem = rem;
    end

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_shift = i_slot;
        end else if (r_busy) begin
            n_cnt   = r_cnt + STEP_W'(1);
            n_shift = r_shift << DIGIT_W;
            if (r_cnt == STEP_W'(MOD_STEPS - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_shift <= n_shift;
        if (i_start) begin
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
        end
    end

    assign o_done = r_busy && (r_cnt == STEP_W'(MOD_STEPS - 1));
    assign o_rem  = n_rem;

endmodule
